/* design/ipdwd_pkg.sv */
// Shared types, register indexes and constants for the IR pulse distance/width decoder.
// No dependencies; imported by every module of the block.
package ipdwd_pkg;

   // Frame and timing constants
   localparam int unsigned MAX_BITS         = 32;
   localparam int unsigned TOLERANCE_PCT    = 25;
   localparam int unsigned REPEAT_GAP_TICKS = 800;

   // Entry positions within one capture
   localparam logic [7:0] FIRST_BIT_INDEX = 8'd3;
   localparam logic [7:0] LENGTH_EXTRA    = 8'd4;
   localparam logic [7:0] INDEX_MAX       = 8'd255;

   // Field widths
   localparam int unsigned DUR_W   = 16;
   localparam int unsigned TICK_W  = 10;
   localparam int unsigned FBITS_W = 6;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned WIN_W   = 11;
   localparam int unsigned CSR_IDX_W = 3;

   // Divide by 100 as multiply by a scaled reciprocal, then shift
   localparam int unsigned RECIP_SHIFT = 26;
   localparam int unsigned K_W         = 28;
   localparam int unsigned PROD_W      = TICK_W + K_W;
   localparam logic [K_W-1:0] RECIP =
      K_W'((64'd1 << RECIP_SHIFT) / 64'd100 + 64'd1);
   localparam logic [K_W-1:0] K_LO = K_W'(64'(RECIP) * 64'(100 - TOLERANCE_PCT));
   localparam logic [K_W-1:0] K_HI = K_W'(64'(RECIP) * 64'(100 + TOLERANCE_PCT));

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_MARK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SPACE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_MARK     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_SPACE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_MARK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_SPACE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BITS   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MSB_FIRST    = 3'd7;

   typedef struct packed {
      logic [WIN_W-1:0] lo;
      logic [WIN_W-1:0] hi;
   } window_type;

   typedef struct packed {
      window_type           header_mark;
      window_type           header_space;
      window_type           one_mark;
      window_type           one_space;
      window_type           zero_mark;
      window_type           zero_space;
      logic [FBITS_W-1:0]   frame_bits;
      logic                 msb_first;
   } cfg_type;

   typedef struct packed {
      logic                decoded;
      logic [WORD_W-1:0]   data_word;
      logic                repeat_res;
   } result_type;

   // Acceptance window: floor(e*(100-T)/100) .. floor(e*(100+T)/100) + 1
   function automatic window_type calc_window(input logic [TICK_W-1:0] e);
      logic [PROD_W-1:0] p_lo;
      logic [PROD_W-1:0] p_hi;
      window_type        w;
      p_lo = PROD_W'(e) * PROD_W'(K_LO);
      p_hi = PROD_W'(e) * PROD_W'(K_HI);
      w.lo = p_lo[RECIP_SHIFT +: WIN_W];
      w.hi = p_hi[RECIP_SHIFT +: WIN_W] + WIN_W'(1);
      return w;
   endfunction

   function automatic logic in_window(input logic [DUR_W-1:0] d, input window_type w);
      return (d >= DUR_W'(w.lo)) && (d <= DUR_W'(w.hi));
   endfunction

endpackage

/* design/ipdwd_csr.sv */
// Configuration registers and registered tolerance windows.
// Depends on ipdwd_pkg.
module ipdwd_csr
   import ipdwd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data,
   output cfg_type              cfg
);

   logic [TICK_W-1:0]  header_mark_ff,  header_mark_in;
   logic [TICK_W-1:0]  header_space_ff, header_space_in;
   logic [TICK_W-1:0]  one_mark_ff,     one_mark_in;
   logic [TICK_W-1:0]  one_space_ff,    one_space_in;
   logic [TICK_W-1:0]  zero_mark_ff,    zero_mark_in;
   logic [TICK_W-1:0]  zero_space_ff,   zero_space_in;
   logic [FBITS_W-1:0] frame_bits_ff,   frame_bits_in;
   logic               msb_first_ff,    msb_first_in;
   cfg_type            cfg_ff,          cfg_in;

   always_comb begin
      header_mark_in  = header_mark_ff;
      header_space_in = header_space_ff;
      one_mark_in     = one_mark_ff;
      one_space_in    = one_space_ff;
      zero_mark_in    = zero_mark_ff;
      zero_space_in   = zero_space_ff;
      frame_bits_in   = frame_bits_ff;
      msb_first_in    = msb_first_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_HEADER_MARK:  header_mark_in  = csr_data;
            CSR_HEADER_SPACE: header_space_in = csr_data;
            CSR_ONE_MARK:     one_mark_in     = csr_data;
            CSR_ONE_SPACE:    one_space_in    = csr_data;
            CSR_ZERO_MARK:    zero_mark_in    = csr_data;
            CSR_ZERO_SPACE:   zero_space_in   = csr_data;
            CSR_FRAME_BITS:   frame_bits_in   = csr_data[FBITS_W-1:0];
            CSR_MSB_FIRST:    msb_first_in    = csr_data[0];
            default: ;
         endcase
      end
   end

   // Windows are registered, so they follow the raw values in the next cycle
   always_comb begin
      cfg_in.header_mark  = calc_window(header_mark_ff);
      cfg_in.header_space = calc_window(header_space_ff);
      cfg_in.one_mark     = calc_window(one_mark_ff);
      cfg_in.one_space    = calc_window(one_space_ff);
      cfg_in.zero_mark    = calc_window(zero_mark_ff);
      cfg_in.zero_space   = calc_window(zero_space_ff);
      cfg_in.frame_bits   = frame_bits_ff;
      cfg_in.msb_first    = msb_first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_mark_ff  <= TICK_W'(51);
         header_space_ff <= TICK_W'(66);
         one_mark_ff     <= TICK_W'(25);
         one_space_ff    <= TICK_W'(8);
         zero_mark_ff    <= TICK_W'(9);
         zero_space_ff   <= TICK_W'(25);
         frame_bits_ff   <= FBITS_W'(16);
         msb_first_ff    <= 1'b0;
      end else begin
         header_mark_ff  <= header_mark_in;
         header_space_ff <= header_space_in;
         one_mark_ff     <= one_mark_in;
         one_space_ff    <= one_space_in;
         zero_mark_ff    <= zero_mark_in;
         zero_space_ff   <= zero_space_in;
         frame_bits_ff   <= frame_bits_in;
         msb_first_ff    <= msb_first_in;
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

/* design/ipdwd_core.sv */
// Capture state, duration matching, bit assembly and the result register.
// Depends on ipdwd_pkg.
module ipdwd_core
   import ipdwd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             step_en,
   input  logic [DUR_W-1:0] duration,
   input  logic             last_entry,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output result_type       result
);

   logic [7:0]        entry_index_ff, entry_index_in;
   logic [WORD_W-1:0] shift_data_ff,  shift_data_in;
   logic              bit_is_one_ff,  bit_is_one_in;
   logic              mismatch_ff,    mismatch_in;
   logic              short_gap_ff,   short_gap_in;
   logic              rsp_valid_ff,   rsp_valid_in;
   result_type        result_ff,      result_in;

   logic [7:0] bit_end;
   logic [7:0] last_index;
   logic [7:0] bit_offset;
   logic [6:0] bit_pos;
   logic       space_ok;
   logic       frame_ok;
   // upd_* is the capture state after this transaction, before any clear
   logic [WORD_W-1:0] upd_shift;
   logic              upd_bit_one;
   logic              upd_mismatch;
   logic              upd_short_gap;

   assign bit_end    = FIRST_BIT_INDEX + {1'b0, cfg.frame_bits, 1'b0};
   assign last_index = {1'b0, cfg.frame_bits, 1'b0} + LENGTH_EXTRA - 8'd1;
   assign bit_offset = entry_index_ff - FIRST_BIT_INDEX;
   assign bit_pos    = bit_offset[7:1];
   assign space_ok   = bit_is_one_ff ? in_window(duration, cfg.one_space)
                                     : in_window(duration, cfg.zero_space);

   always_comb begin
      upd_shift     = shift_data_ff;
      upd_bit_one   = bit_is_one_ff;
      upd_mismatch  = mismatch_ff;
      upd_short_gap = short_gap_ff;
      if (entry_index_ff == 8'd0) begin
         upd_short_gap = (duration < DUR_W'(REPEAT_GAP_TICKS));
      end else if (entry_index_ff == 8'd1) begin
         if (!in_window(duration, cfg.header_mark)) upd_mismatch = 1'b1;
      end else if (entry_index_ff == 8'd2) begin
         if (!in_window(duration, cfg.header_space)) upd_mismatch = 1'b1;
      end else if (entry_index_ff < bit_end) begin
         if (entry_index_ff[0]) begin
            // mark: one window takes priority when windows overlap
            if (in_window(duration, cfg.one_mark)) begin
               upd_bit_one = 1'b1;
            end else if (in_window(duration, cfg.zero_mark)) begin
               upd_bit_one = 1'b0;
            end else begin
               upd_mismatch = 1'b1;
            end
         end else begin
            if (!space_ok) begin
               upd_mismatch = 1'b1;
            end else if (cfg.msb_first) begin
               upd_shift = {shift_data_ff[WORD_W-2:0], bit_is_one_ff};
            end else if (bit_is_one_ff && (bit_pos < 7'(WORD_W))) begin
               upd_shift[bit_pos[4:0]] = 1'b1;
            end
         end
      end
   end

   assign frame_ok = !upd_mismatch
                  && (7'(cfg.frame_bits) <= 7'(MAX_BITS))
                  && (entry_index_ff == last_index);

   always_comb begin
      entry_index_in = entry_index_ff;
      shift_data_in  = shift_data_ff;
      bit_is_one_in  = bit_is_one_ff;
      mismatch_in    = mismatch_ff;
      short_gap_in   = short_gap_ff;
      if (step_en) begin
         if (last_entry) begin
            entry_index_in = 8'd0;
            shift_data_in  = '0;
            bit_is_one_in  = 1'b0;
            mismatch_in    = 1'b0;
            short_gap_in   = 1'b0;
         end else begin
            entry_index_in = (entry_index_ff == INDEX_MAX) ? INDEX_MAX
                                                           : entry_index_ff + 8'd1;
            shift_data_in  = upd_shift;
            bit_is_one_in  = upd_bit_one;
            mismatch_in    = upd_mismatch;
            short_gap_in   = upd_short_gap;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      result_in    = result_ff;
      if (step_en && last_entry) begin
         rsp_valid_in         = 1'b1;
         result_in.decoded    = frame_ok;
         result_in.data_word  = frame_ok ? upd_shift : '0;
         result_in.repeat_res = frame_ok && upd_short_gap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_index_ff <= 8'd0;
         shift_data_ff  <= '0;
         bit_is_one_ff  <= 1'b0;
         mismatch_ff    <= 1'b0;
         short_gap_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_index_ff <= entry_index_in;
         shift_data_ff  <= shift_data_in;
         bit_is_one_ff  <= bit_is_one_in;
         mismatch_ff    <= mismatch_in;
         short_gap_ff   <= short_gap_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

/* design/ir_pulse_distance_width_decoder.sv */
// Top level of the IR pulse distance/width frame decoder: input register and handshake.
// Depends on ipdwd_pkg, ipdwd_csr and ipdwd_core.
//
// Usage:
//  - req_ channel: one captured duration per transaction (leading gap, header mark,
//    header space, mark/space per bit, stop mark); req_last_entry closes a capture.
//  - rsp_ channel: exactly one result transaction per capture, produced by the
//    transaction that carries req_last_entry; all other transactions give none.
//  - csr_ port: plain write port, one register per csr_index; write only while idle.
//    A write applies to transactions accepted from the following edge on; the
//    delay of the window register is hidden by the input register.
//  - Result path: the closing transaction moves from the input register to the result
//    register, held back while an older result waits; rsp_valid is high until taken.
//  - Throughput: one transaction per cycle unless a closing one is held. Matching and
//    bit assembly are a single compare stage between the input and result registers.
//  - Stall: while a result waits on rsp_ready, non-closing transactions keep flowing;
//    a second closing transaction holds in the input register, and req_ready
//    drops only once that register is also occupied.
//  - Reset: clears the capture state, both valid flags and loads register defaults.
module ir_pulse_distance_width_decoder
   import ipdwd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DUR_W-1:0]     req_duration,
   input  logic                 req_last_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_decoded,
   output logic [WORD_W-1:0]    rsp_data_word,
   output logic [7:0]           rsp_address_byte,
   output logic [7:0]           rsp_command_byte,
   output logic                 rsp_repeat_res,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data
);

   logic             in_valid_ff, in_valid_in;
   logic [DUR_W-1:0] in_duration_ff, in_duration_in;
   logic             in_last_ff, in_last_in;
   logic             advance;
   cfg_type          cfg;
   result_type       result;

   ipdwd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   // The held transaction moves on unless it would produce a result
   // while the result register is full and not being drained.
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in    = in_valid_ff && !advance;
      in_duration_in = in_duration_ff;
      in_last_in     = in_last_ff;
      if (req_valid && req_ready) begin
         in_valid_in    = 1'b1;
         in_duration_in = req_duration;
         in_last_in     = req_last_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_duration_ff <= in_duration_in;
      in_last_ff     <= in_last_in;
   end

   ipdwd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_en    (advance),
      .duration   (in_duration_ff),
      .last_entry (in_last_ff),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .result     (result)
   );

   assign rsp_decoded      = result.decoded;
   assign rsp_data_word    = result.data_word;
   assign rsp_address_byte = result.data_word[7:0];
   assign rsp_command_byte = result.data_word[15:8];
   assign rsp_repeat_res   = result.repeat_res;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for ir_pulse_distance_width_decoder: directed table, then random captures.
// Depends on ipdwd_pkg (widths, register indexes, timing constants) and the decoder RTL.
module tb_top;
   import ipdwd_pkg::*;

   // Timing of the run
   localparam int unsigned RESET_CYCLES = 11;
   localparam int unsigned DRAIN_CYCLES = 6;      // covers the result register, plus margin
   localparam int unsigned CSR_SETTLE   = 2;      // windows are recomputed into a register
   localparam int unsigned IDLE_MAX     = 17;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned ITEM_TARGET  = 900;
   localparam int unsigned PHASE_ITEMS  = 60;

   // One result transaction, in port order
   typedef struct packed {
      logic              decoded;
      logic [WORD_W-1:0] data_word;
      logic [7:0]        address_byte;
      logic [7:0]        command_byte;
      logic              repeat_res;
   } frame_result_type;

   localparam frame_result_type NO_FRAME = '0;

   // Register file image, indexed by the CSR_* codes
   typedef logic [7:0][TICK_W-1:0] reg_image_type;

   // Directed row: one duration; a pinned row carries its expected result
   typedef struct packed {
      logic [DUR_W-1:0] dur;
      logic             last;
      logic             pinned;
      frame_result_type res;
   } stim_row_type;

   // Directed part runs with two data bits per frame (length 8), other registers at defaults.
   localparam int unsigned DIRECTED_ROWS = 20;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // lone leading gap: too short for any frame
      '{16'd700,   1'b1, 1'b1, NO_FRAME},
      // clean frame, short gap (repeat), bits one then zero
      '{16'd700,   1'b0, 1'b0, NO_FRAME},
      '{16'd51,    1'b0, 1'b0, NO_FRAME},
      '{16'd66,    1'b0, 1'b0, NO_FRAME},
      '{16'd25,    1'b0, 1'b0, NO_FRAME},
      '{16'd8,     1'b0, 1'b0, NO_FRAME},
      '{16'd9,     1'b0, 1'b0, NO_FRAME},
      '{16'd25,    1'b0, 1'b0, NO_FRAME},
      '{16'd9,     1'b1, 1'b0, NO_FRAME},
      // every duration on a window edge, longest gap, zero-length stop mark
      '{16'hFFFF,  1'b0, 1'b0, NO_FRAME},
      '{16'd38,    1'b0, 1'b0, NO_FRAME},
      '{16'd83,    1'b0, 1'b0, NO_FRAME},
      '{16'd18,    1'b0, 1'b0, NO_FRAME},
      '{16'd6,     1'b0, 1'b0, NO_FRAME},
      '{16'd12,    1'b0, 1'b0, NO_FRAME},
      '{16'd32,    1'b0, 1'b0, NO_FRAME},
      '{16'd0,     1'b1, 1'b0, NO_FRAME},
      // header mark one tick under its window, capture cut short
      '{16'd0,     1'b0, 1'b1, NO_FRAME},
      '{16'd37,    1'b0, 1'b1, NO_FRAME},
      '{16'd66,    1'b1, 1'b1, NO_FRAME}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [DUR_W-1:0]     req_duration;
   logic                 req_last_entry;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_decoded;
   logic [WORD_W-1:0]    rsp_data_word;
   logic [7:0]           rsp_address_byte;
   logic [7:0]           rsp_command_byte;
   logic                 rsp_repeat_res;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TICK_W-1:0]    csr_data;

   ir_pulse_distance_width_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_duration     (req_duration),
      .req_last_entry   (req_last_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_decoded      (rsp_decoded),
      .rsp_data_word    (rsp_data_word),
      .rsp_address_byte (rsp_address_byte),
      .rsp_command_byte (rsp_command_byte),
      .rsp_repeat_res   (rsp_repeat_res),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Decoder settings as the predictor sees them (masked to register widths)
   logic [TICK_W-1:0]  hdr_mark_q, hdr_space_q;
   logic [TICK_W-1:0]  one_mark_q, one_space_q;
   logic [TICK_W-1:0]  zero_mark_q, zero_space_q;
   logic [FBITS_W-1:0] nbits_q;
   logic               msb_q;

   // Capture state of the predictor
   logic [7:0]         cap_pos;
   logic [WORD_W-1:0]  cap_word;
   bit                 cap_one, cap_bad, cap_short;

   frame_result_type   expected_frames[$];
   int unsigned        errors = 0;
   int unsigned        cycles = 0;
   int unsigned        items_sent = 0;
   int unsigned        rsp_taken = 0;
   bit                 req_burst = 1'b0;
   bit                 rsp_burst = 1'b0;

   // ---------------------------------------------------------------- clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Tolerance window: floor(e*(100-T)/100) .. floor(e*(100+T)/100) + 1
   function automatic void tol_bounds(input logic [TICK_W-1:0] e,
                                      output int unsigned lo, output int unsigned hi);
      lo = (int'(e) * (100 - TOLERANCE_PCT)) / 100;
      hi = (int'(e) * (100 + TOLERANCE_PCT)) / 100 + 1;
   endfunction

   function automatic bit in_tol(input logic [DUR_W-1:0] d, input logic [TICK_W-1:0] e);
      int unsigned lo, hi;
      tol_bounds(e, lo, hi);
      return (int'(d) >= lo) && (int'(d) <= hi);
   endfunction

   function automatic logic [DUR_W-1:0] pick_in_tol(input logic [TICK_W-1:0] e);
      int unsigned lo, hi;
      tol_bounds(e, lo, hi);
      return DUR_W'($urandom_range(hi, lo));
   endfunction

   task automatic clear_capture();
      cap_pos   = '0;
      cap_word  = '0;
      cap_one   = 1'b0;
      cap_bad   = 1'b0;
      cap_short = 1'b0;
   endtask

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
      case (idx)
         CSR_HEADER_MARK:  hdr_mark_q   = val;
         CSR_HEADER_SPACE: hdr_space_q  = val;
         CSR_ONE_MARK:     one_mark_q   = val;
         CSR_ONE_SPACE:    one_space_q  = val;
         CSR_ZERO_MARK:    zero_mark_q  = val;
         CSR_ZERO_SPACE:   zero_space_q = val;
         CSR_FRAME_BITS:   nbits_q      = val[FBITS_W-1:0];
         CSR_MSB_FIRST:    msb_q        = val[0];
         default: ;
      endcase
   endtask

   // Advance the capture by one duration; on the closing entry, produce the frame result.
   task automatic decode_duration(input logic [DUR_W-1:0] dur, input bit last,
                                  output bit has_res, output frame_result_type res);
      int unsigned pos, bit_end, k;
      bit ok;
      pos     = cap_pos;
      bit_end = FIRST_BIT_INDEX + 2 * nbits_q;
      has_res = 1'b0;
      res     = NO_FRAME;
      if (pos == 0) begin
         cap_short = (int'(dur) < REPEAT_GAP_TICKS);
      end else if (pos == 1) begin
         if (!in_tol(dur, hdr_mark_q)) cap_bad = 1'b1;
      end else if (pos == 2) begin
         if (!in_tol(dur, hdr_space_q)) cap_bad = 1'b1;
      end else if (pos < bit_end) begin
         if (pos % 2 == 1) begin
            // mark: the one window takes precedence where both match
            if (in_tol(dur, one_mark_q)) cap_one = 1'b1;
            else if (in_tol(dur, zero_mark_q)) cap_one = 1'b0;
            else cap_bad = 1'b1;
         end else begin
            k  = (pos - FIRST_BIT_INDEX) / 2;
            ok = cap_one ? in_tol(dur, one_space_q) : in_tol(dur, zero_space_q);
            if (!ok) cap_bad = 1'b1;
            else if (msb_q) cap_word = {cap_word[WORD_W-2:0], cap_one};
            else if (cap_one && k < WORD_W) cap_word[k] = 1'b1;
         end
      end
      // stop mark and anything past it is only counted
      if (cap_pos != INDEX_MAX) cap_pos = cap_pos + 8'd1;
      if (last) begin
         ok = !cap_bad && (nbits_q <= MAX_BITS) && (pos == 2 * nbits_q + LENGTH_EXTRA - 1);
         if (ok) begin
            res.decoded      = 1'b1;
            res.data_word    = cap_word;
            res.address_byte = cap_word[7:0];
            res.command_byte = cap_word[15:8];
            res.repeat_res   = cap_short;
         end
         has_res = 1'b1;
         clear_capture();
      end
   endtask

   // ---------------------------------------------------------------- request side

   // Drive one duration, wait for its transaction, then log the expected result.
   // Returns on a falling edge so the next call may drive right away.
   task automatic push_duration(input logic [DUR_W-1:0] dur, input bit last,
                                input bit pinned, input frame_result_type pinned_res);
      int unsigned gap;
      bit has_res;
      frame_result_type res;
      gap = req_burst ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_duration   <= dur;
      req_last_entry <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_duration(dur, last, has_res, res);
      if (has_res) expected_frames.push_back(pinned ? pinned_res : res);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_capture(input logic [DUR_W-1:0] durs[$]);
      int unsigned i;
      for (i = 0; i < durs.size(); i++) push_duration(durs[i], i == durs.size() - 1, 1'b0, NO_FRAME);
   endtask

   // Hold the sender until every expected result is in, then let the pipe empty.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic program_regs(input reg_image_type img);
      int unsigned i;
      for (i = 0; i < 8; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= CSR_IDX_W'(i);
         csr_data     <= img[i];
         apply_reg(CSR_IDX_W'(i), img[i]);
         @(negedge clock);
      end
      csr_write_en <= 1'b0;
      repeat (CSR_SETTLE) @(negedge clock);
   endtask

   function automatic reg_image_type make_image(input logic [TICK_W-1:0] hm, hs, om, os, zm, zs,
                                                input logic [TICK_W-1:0] nb, order);
      reg_image_type img;
      img[CSR_HEADER_MARK]  = hm;
      img[CSR_HEADER_SPACE] = hs;
      img[CSR_ONE_MARK]     = om;
      img[CSR_ONE_SPACE]    = os;
      img[CSR_ZERO_MARK]    = zm;
      img[CSR_ZERO_SPACE]   = zs;
      img[CSR_FRAME_BITS]   = nb;
      img[CSR_MSB_FIRST]    = order;
      return img;
   endfunction

   // One capture of random shape: mostly proper frames, some damaged, some noise,
   // now and then one long enough to saturate the entry counter.
   task automatic run_capture(input bit force_long);
      logic [DUR_W-1:0] durs[$];
      int unsigned pick, i, n, idx;
      bit one;
      req_burst = ($urandom_range(0, 4) == 0);
      rsp_burst = ($urandom_range(0, 4) == 0);
      pick = force_long ? 99 : $urandom_range(0, 99);
      if (pick < 85) begin
         case ($urandom_range(0, 5))
            0:       durs.push_back(DUR_W'($urandom_range(0, REPEAT_GAP_TICKS - 1)));
            1:       durs.push_back(DUR_W'(REPEAT_GAP_TICKS - 1));
            2:       durs.push_back(DUR_W'(REPEAT_GAP_TICKS));
            3:       durs.push_back(DUR_W'($urandom));
            default: durs.push_back(DUR_W'($urandom_range(REPEAT_GAP_TICKS, 65535)));
         endcase
         durs.push_back(pick_in_tol(hdr_mark_q));
         durs.push_back(pick_in_tol(hdr_space_q));
         for (i = 0; i < nbits_q; i++) begin
            one = 1'($urandom_range(0, 1));
            durs.push_back(pick_in_tol(one ? one_mark_q : zero_mark_q));
            durs.push_back(pick_in_tol(one ? one_space_q : zero_space_q));
         end
         durs.push_back(DUR_W'($urandom_range(0, 1023)));
         if (pick >= 70) begin
            idx = $urandom_range(0, durs.size() - 1);
            case ($urandom_range(0, 3))
               0: durs[idx] = DUR_W'($urandom);
               1: if (durs.size() > 1) void'(durs.pop_back());
               2: durs.push_back(DUR_W'($urandom_range(0, 1300)));
               default: durs[idx] = durs[idx] + DUR_W'($urandom_range(1, 40));
            endcase
         end
      end else begin
         n = (pick < 99) ? $urandom_range(1, 2 * nbits_q + 8) : $urandom_range(256, 300);
         for (i = 0; i < n; i++)
            durs.push_back($urandom_range(0, 1) ? DUR_W'($urandom)
                                                : DUR_W'($urandom_range(0, 1300)));
      end
      send_capture(durs);
      // sender holds off now and then until the result side has caught up
      if ($urandom_range(0, 7) == 0) wait_drained();
   endtask

   task automatic run_phase(input reg_image_type img, input bit force_long);
      int unsigned start;
      wait_drained();
      program_regs(img);
      start = items_sent;
      run_capture(force_long);
      while (items_sent - start < PHASE_ITEMS) run_capture(1'b0);
   endtask

   // ---------------------------------------------------------------- result side

   task automatic report_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
      $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
      errors++;
   endtask

   // Receiver stall: drawn per result, counted down on falling edges
   initial begin
      int unsigned seen, hold;
      seen      = 0;
      hold      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_taken != seen) begin
            seen = rsp_taken;
            hold = rsp_burst ? 0 : $urandom_range(0, IDLE_MAX);
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every result transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      frame_result_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_decoded, rsp_data_word, rsp_address_byte, rsp_command_byte,
                 rsp_repeat_res};
         if (expected_frames.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $realtime, got);
            errors++;
         end else begin
            want = expected_frames.pop_front();
            if (got.decoded !== want.decoded)
               report_field("decoded", WORD_W'(want.decoded), WORD_W'(got.decoded));
            if (got.data_word !== want.data_word)
               report_field("data_word", want.data_word, got.data_word);
            if (got.address_byte !== want.address_byte)
               report_field("address_byte", WORD_W'(want.address_byte),
                            WORD_W'(got.address_byte));
            if (got.command_byte !== want.command_byte)
               report_field("command_byte", WORD_W'(want.command_byte),
                            WORD_W'(got.command_byte));
            if (got.repeat_res !== want.repeat_res)
               report_field("repeat_res", WORD_W'(want.repeat_res), WORD_W'(got.repeat_res));
         end
         rsp_taken++;
      end
   end

   // Watchdog on the whole run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $realtime,
                  expected_frames.size());
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      reg_image_type img;
      int unsigned i, nb;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_duration   = '0;
      req_last_entry = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_data       = '0;

      // predictor starts from the register defaults
      hdr_mark_q   = 10'd51;
      hdr_space_q  = 10'd66;
      one_mark_q   = 10'd25;
      one_space_q  = 10'd8;
      zero_mark_q  = 10'd9;
      zero_space_q = 10'd25;
      nbits_q      = 6'd16;
      msb_q        = 1'b0;
      clear_capture();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table: short frames so the whole set stays small
      program_regs(make_image(10'd51, 10'd66, 10'd25, 10'd8, 10'd9, 10'd25, 10'd2, 10'd0));
      for (i = 0; i < DIRECTED_ROWS; i++)
         push_duration(DIRECTED[i].dur, DIRECTED[i].last, DIRECTED[i].pinned, DIRECTED[i].res);

      // fixed settings: defaults, widest word, largest and smallest windows,
      // identical one/zero marks, no data bits, bit counts past the word
      run_phase(make_image(10'd51, 10'd66, 10'd25, 10'd8, 10'd9, 10'd25, 10'd16, 10'd0), 1'b1);
      run_phase(make_image(10'd51, 10'd66, 10'd25, 10'd8, 10'd9, 10'd25, 10'd32, 10'd1), 1'b0);
      run_phase(make_image(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                           10'd32, 10'd0), 1'b0);
      run_phase(make_image(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1), 1'b0);
      run_phase(make_image(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0), 1'b0);
      run_phase(make_image(10'd40, 10'd80, 10'd30, 10'd12, 10'd10, 10'd30, 10'd40, 10'd0), 1'b0);
      run_phase(make_image(10'd40, 10'd80, 10'd30, 10'd12, 10'd10, 10'd30, 10'd63, 10'd1), 1'b0);

      // random settings; unused upper bits of the narrow registers are randomized too
      while (items_sent < ITEM_TARGET) begin
         for (i = CSR_HEADER_MARK; i <= CSR_ZERO_SPACE; i++)
            img[i] = ($urandom_range(0, 5) == 0) ? TICK_W'($urandom_range(0, 15))
                                                 : TICK_W'($urandom_range(1, 1023));
         nb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
         img[CSR_FRAME_BITS] = {4'($urandom), FBITS_W'(nb)};
         img[CSR_MSB_FIRST]  = TICK_W'($urandom);
         run_phase(img, 1'b0);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
